// File: rtl/vfc_pkg.sv
// Shared types, constants and the key function for the voxel face culler.
// No dependencies; every other file imports this package.
`default_nettype none

package vfc_pkg;

    // defaults for the top-level parameters
    localparam int STORE_DEPTH_DEF = 4096;
    localparam int MAX_EXTENT_DEF  = 64;

    // fixed field widths
    localparam int MODE_W     = 3;
    localparam int CRD_W      = 6;
    localparam int COL_W      = 8;
    localparam int FACE_W     = 6;
    localparam int IDX_W      = 12;
    localparam int CNT_OUT_W  = 13;
    localparam int SZ_W       = 7;
    localparam int CAP_W      = 13;
    localparam int SXY_W      = 2 * SZ_W;
    localparam int KEY_W      = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int GAP_W      = 10;
    localparam int NUM_GAPS   = 8;
    localparam int GIDX_W     = 4;
    localparam int FIDX_W     = 3;

    // item modes
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FINISH = 3'd2;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd3;

    localparam logic [FACE_W-1:0] ALL_FACES = 6'h3F;
    localparam logic [FIDX_W-1:0] FACE_COUNT = 3'd6;

    // shell sort gap sequence
    typedef logic [GAP_W-1:0] gap_t;
    localparam gap_t GAPS [NUM_GAPS] = '{10'd701, 10'd301, 10'd132, 10'd57,
                                         10'd23, 10'd10, 10'd4, 10'd1};

    typedef struct packed {
        logic [CRD_W-1:0]  x;
        logic [CRD_W-1:0]  y;
        logic [CRD_W-1:0]  z;
        logic [COL_W-1:0]  color;
        logic [FACE_W-1:0] faces;
    } voxel_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_RD_OUT,
        S_SORT_GAP, S_SORT_RDI, S_SORT_LDT, S_SORT_RDJ, S_SORT_CMP,
        S_DD_RD0, S_DD_K0, S_DD_RD, S_DD_CHK,
        S_FC_RD, S_FC_LD, S_FC_NB, S_FB_RD, S_FB_CMP,
        S_CL_RD, S_CL_CHK,
        S_QB_RD, S_QB_CMP, S_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_ACCEPT, OP_CLEAR, OP_LOAD, OP_RD_ENTRY, OP_RD_OUT,
        OP_SORT_INIT, OP_GAP_NEXT, OP_GAP_BEGIN, OP_RD_I, OP_LD_T, OP_RD_JG,
        OP_SHIFT, OP_PLACE, OP_SORT_DONE,
        OP_RD_ZERO, OP_DD_K0, OP_DD_CHK, OP_DD_END,
        OP_FC_LD, OP_FC_MISS, OP_FC_HIT, OP_FB_INIT, OP_FC_WR,
        OP_QY_INIT, OP_BS_RD, OP_BS_STEP, OP_QY_HIT,
        OP_CL_INIT, OP_CL_CHK, OP_CL_END
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic count_zero;
        logic is_culled;
        logic query_ok;
        logic read_ok;
        logic gaps_done;
        logic gap_skip;
        logic i_lt_n;
        logic j_ge_gap;
        logic key_gt;
        logic faces_done;
        logic nb_out;
        logic bs_open;
        logic bs_hit;
    } dp_status_t;

    // sort key (z*sy + y)*sx + x, with sxy = sx*sy
    function automatic logic [KEY_W-1:0] key_of(
        input logic [CRD_W-1:0] x,
        input logic [CRD_W-1:0] y,
        input logic [CRD_W-1:0] z,
        input logic [SZ_W-1:0]  sx,
        input logic [SXY_W-1:0] sxy
    );
        logic [KEY_W-1:0] zp;
        logic [KEY_W-1:0] yp;
        zp = KEY_W'(z) * KEY_W'(sxy);
        yp = KEY_W'(y) * KEY_W'(sx);
        return zp + yp + KEY_W'(x);
    endfunction

endpackage

`default_nettype wire

// File: rtl/vfc_ctrl.sv
// Controller state machine of the voxel face culler.
// Depends on vfc_pkg; drives vfc_datapath by command word, reads its status.
`default_nettype none

module vfc_ctrl
    import vfc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  dp_status_t      st,
    output dp_cmd_t         cmd,
    output logic            busy,
    output logic            done
);

    state_t state_reg;
    state_t state_next;

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // sequence commands for each mode
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        busy       = (state_reg != S_IDLE);
        done       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_ACCEPT;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_DONE;
                case (st.mode)
                    MODE_CLEAR:  cmd.op = OP_CLEAR;
                    MODE_LOAD:   cmd.op = OP_LOAD;
                    MODE_FINISH:
                    begin
                        if (!st.count_zero)
                        begin
                            cmd.op     = OP_SORT_INIT;
                            state_next = S_SORT_GAP;
                        end
                    end
                    MODE_QUERY:
                    begin
                        if (st.query_ok)
                        begin
                            cmd.op     = OP_QY_INIT;
                            state_next = S_QB_RD;
                        end
                    end
                    MODE_READ:
                    begin
                        if (st.read_ok)
                        begin
                            cmd.op     = OP_RD_ENTRY;
                            state_next = S_RD_OUT;
                        end
                    end
                    default: cmd.op = OP_NONE;
                endcase
            end
            S_RD_OUT:
            begin
                cmd.op     = OP_RD_OUT;
                state_next = S_DONE;
            end
            // shell sort passes
            S_SORT_GAP:
            begin
                if (st.gaps_done)
                begin
                    cmd.op     = OP_SORT_DONE;
                    state_next = st.is_culled ? S_DONE : S_DD_RD0;
                end
                else if (st.gap_skip)
                begin
                    cmd.op = OP_GAP_NEXT;
                end
                else
                begin
                    cmd.op     = OP_GAP_BEGIN;
                    state_next = S_SORT_RDI;
                end
            end
            S_SORT_RDI:
            begin
                if (st.i_lt_n)
                begin
                    cmd.op     = OP_RD_I;
                    state_next = S_SORT_LDT;
                end
                else
                begin
                    cmd.op     = OP_GAP_NEXT;
                    state_next = S_SORT_GAP;
                end
            end
            S_SORT_LDT:
            begin
                cmd.op     = OP_LD_T;
                state_next = S_SORT_RDJ;
            end
            S_SORT_RDJ:
            begin
                if (st.j_ge_gap)
                begin
                    cmd.op     = OP_RD_JG;
                    state_next = S_SORT_CMP;
                end
                else
                begin
                    cmd.op     = OP_PLACE;
                    state_next = S_SORT_RDI;
                end
            end
            S_SORT_CMP:
            begin
                if (st.key_gt)
                begin
                    cmd.op     = OP_SHIFT;
                    state_next = S_SORT_RDJ;
                end
                else
                begin
                    cmd.op     = OP_PLACE;
                    state_next = S_SORT_RDI;
                end
            end
            // drop duplicate keys
            S_DD_RD0:
            begin
                cmd.op     = OP_RD_ZERO;
                state_next = S_DD_K0;
            end
            S_DD_K0:
            begin
                cmd.op     = OP_DD_K0;
                state_next = S_DD_RD;
            end
            S_DD_RD:
            begin
                if (st.i_lt_n)
                begin
                    cmd.op     = OP_RD_I;
                    state_next = S_DD_CHK;
                end
                else
                begin
                    cmd.op     = OP_DD_END;
                    state_next = S_FC_RD;
                end
            end
            S_DD_CHK:
            begin
                cmd.op     = OP_DD_CHK;
                state_next = S_DD_RD;
            end
            // face masks
            S_FC_RD:
            begin
                if (st.i_lt_n)
                begin
                    cmd.op     = OP_RD_I;
                    state_next = S_FC_LD;
                end
                else
                begin
                    cmd.op     = OP_CL_INIT;
                    state_next = S_CL_RD;
                end
            end
            S_FC_LD:
            begin
                cmd.op     = OP_FC_LD;
                state_next = S_FC_NB;
            end
            S_FC_NB:
            begin
                if (st.faces_done)
                begin
                    cmd.op     = OP_FC_WR;
                    state_next = S_FC_RD;
                end
                else if (st.nb_out)
                begin
                    cmd.op = OP_FC_MISS;
                end
                else
                begin
                    cmd.op     = OP_FB_INIT;
                    state_next = S_FB_RD;
                end
            end
            S_FB_RD:
            begin
                if (st.bs_open)
                begin
                    cmd.op     = OP_BS_RD;
                    state_next = S_FB_CMP;
                end
                else
                begin
                    cmd.op     = OP_FC_MISS;
                    state_next = S_FC_NB;
                end
            end
            S_FB_CMP:
            begin
                if (st.bs_hit)
                begin
                    cmd.op     = OP_FC_HIT;
                    state_next = S_FC_NB;
                end
                else
                begin
                    cmd.op     = OP_BS_STEP;
                    state_next = S_FB_RD;
                end
            end
            // compact away faceless voxels
            S_CL_RD:
            begin
                if (st.i_lt_n)
                begin
                    cmd.op     = OP_RD_I;
                    state_next = S_CL_CHK;
                end
                else
                begin
                    cmd.op     = OP_CL_END;
                    state_next = S_DONE;
                end
            end
            S_CL_CHK:
            begin
                cmd.op     = OP_CL_CHK;
                state_next = S_CL_RD;
            end
            // occupancy query
            S_QB_RD:
            begin
                if (st.bs_open)
                begin
                    cmd.op     = OP_BS_RD;
                    state_next = S_QB_CMP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_QB_CMP:
            begin
                if (st.bs_hit)
                begin
                    cmd.op     = OP_QY_HIT;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_BS_STEP;
                    state_next = S_QB_RD;
                end
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted word did not raise busy");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (busy && cmd.op == OP_NONE))
        else $error("result strobe while datapath still commanded");

endmodule

`default_nettype wire

// File: rtl/vfc_datapath.sv
// Datapath of the voxel face culler: voxel memory, counters, keys, results.
// Depends on vfc_pkg; executes one command word from vfc_ctrl per cycle.
`default_nettype none

module vfc_datapath
    import vfc_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int MAX_EXTENT  = MAX_EXTENT_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  dp_cmd_t                    cmd,
    output dp_status_t                 st,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data,
    input  wire logic [MODE_W-1:0]     mode,
    input  wire logic [CRD_W-1:0]      pos_x,
    input  wire logic [CRD_W-1:0]      pos_y,
    input  wire logic [CRD_W-1:0]      pos_z,
    input  wire logic [COL_W-1:0]      color,
    input  wire logic [IDX_W-1:0]      entry_index,
    output logic                       ok,
    output logic [CNT_OUT_W-1:0]       removed_count,
    output logic [CNT_OUT_W-1:0]       voxel_count,
    output logic [CRD_W-1:0]           out_x,
    output logic [CRD_W-1:0]           out_y,
    output logic [CRD_W-1:0]           out_z,
    output logic [COL_W-1:0]           out_color,
    output logic [FACE_W-1:0]          out_faces
);

    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);

    // configuration and control state
    logic [SZ_W-1:0]   sx_reg, sy_reg, sz_reg;
    logic [CAP_W-1:0]  cap_reg;
    logic [SXY_W-1:0]  sxy_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              sorted_reg, culled_reg;
    logic [GIDX_W-1:0] gidx_reg;
    logic [GAP_W-1:0]  gap_reg;
    logic [CNT_W-1:0]  i_reg, j_reg, w_reg, lo_reg, hi_reg, before_reg;
    logic [FIDX_W-1:0] fidx_reg;
    logic [FACE_W-1:0] fmask_reg;

    // payload
    logic [MODE_W-1:0] mode_reg;
    logic [CRD_W-1:0]  px_reg, py_reg, pz_reg;
    logic [COL_W-1:0]  col_reg;
    logic [IDX_W-1:0]  idx_reg;
    voxel_t            t_reg, cur_reg, rdata_reg, res_vox_reg;
    logic [KEY_W-1:0]  tkey_reg, lastkey_reg, want_reg;
    logic              res_ok_reg;
    logic [CNT_W-1:0]  res_removed_reg;

    voxel_t store_mem [STORE_DEPTH];

    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    voxel_t            mem_wdata;

    logic [SZ_W-1:0]   esx, esy, esz;
    logic [KEY_W-1:0]  rkey, nbkey, qkey;
    logic [CNT_W:0]    mid_sum;
    logic [CNT_W-1:0]  mid;
    logic [SZ_W-1:0]   nbx, nby, nbz;
    logic              load_ok;
    logic [GAP_W-1:0]  gap_cur;

    // clamp sizes to the supported extent
    always_comb
    begin
        esx = (32'(sx_reg) > MAX_EXTENT) ? SZ_W'(MAX_EXTENT) : sx_reg;
        esy = (32'(sy_reg) > MAX_EXTENT) ? SZ_W'(MAX_EXTENT) : sy_reg;
        esz = (32'(sz_reg) > MAX_EXTENT) ? SZ_W'(MAX_EXTENT) : sz_reg;
    end

    assign rkey    = key_of(rdata_reg.x, rdata_reg.y, rdata_reg.z, esx, sxy_reg);
    assign qkey    = key_of(px_reg, py_reg, pz_reg, esx, sxy_reg);
    assign nbkey   = key_of(nbx[CRD_W-1:0], nby[CRD_W-1:0], nbz[CRD_W-1:0], esx, sxy_reg);
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CNT_W:1];
    assign gap_cur = GAPS[gidx_reg[FIDX_W-1:0]];
    assign load_ok = (32'(count_reg) < 32'(cap_reg)) && (32'(count_reg) < STORE_DEPTH) &&
                     (col_reg != '0) && ({1'b0, px_reg} < esx) &&
                     ({1'b0, py_reg} < esy) && ({1'b0, pz_reg} < esz);

    // neighbor of the current voxel for the face under test; underflow wraps high
    always_comb
    begin
        nbx = {1'b0, cur_reg.x};
        nby = {1'b0, cur_reg.y};
        nbz = {1'b0, cur_reg.z};
        case (fidx_reg)
            3'd0:    nbx = nbx + 1'b1;
            3'd1:    nbx = nbx - 1'b1;
            3'd2:    nby = nby + 1'b1;
            3'd3:    nby = nby - 1'b1;
            3'd4:    nbz = nbz + 1'b1;
            3'd5:    nbz = nbz - 1'b1;
            default: nbx = nbx;
        endcase
    end

    // report status
    always_comb
    begin
        st.mode       = mode_reg;
        st.count_zero = (count_reg == '0);
        st.is_culled  = culled_reg;
        st.query_ok   = sorted_reg && (count_reg != '0) && ({1'b0, px_reg} < esx) &&
                        ({1'b0, py_reg} < esy) && ({1'b0, pz_reg} < esz);
        st.read_ok    = (32'(idx_reg) < 32'(count_reg));
        st.gaps_done  = (gidx_reg == GIDX_W'(NUM_GAPS));
        st.gap_skip   = (32'(gap_cur) >= 32'(count_reg));
        st.i_lt_n     = (i_reg < count_reg);
        st.j_ge_gap   = (32'(j_reg) >= 32'(gap_reg));
        st.key_gt     = (rkey > tkey_reg);
        st.faces_done = (fidx_reg == FACE_COUNT);
        st.nb_out     = (nbx >= esx) || (nby >= esy) || (nbz >= esz);
        st.bs_open    = (lo_reg < hi_reg);
        st.bs_hit     = (rkey == want_reg);
    end

    // drive memory ports per command
    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = j_reg[AW-1:0];
        mem_raddr = i_reg[AW-1:0];
        mem_wdata = rdata_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                mem_we    = load_ok;
                mem_waddr = count_reg[AW-1:0];
                mem_wdata = '{x: px_reg, y: py_reg, z: pz_reg, color: col_reg,
                              faces: ALL_FACES};
            end
            OP_RD_ENTRY:
            begin
                mem_re    = 1'b1;
                mem_raddr = AW'(idx_reg);
            end
            OP_RD_I:     mem_re = 1'b1;
            OP_RD_ZERO:
            begin
                mem_re    = 1'b1;
                mem_raddr = '0;
            end
            OP_RD_JG:
            begin
                mem_re    = 1'b1;
                mem_raddr = AW'(j_reg - CNT_W'(gap_reg));
            end
            OP_SHIFT:    mem_we = 1'b1;
            OP_PLACE:
            begin
                mem_we    = 1'b1;
                mem_wdata = t_reg;
            end
            OP_DD_CHK:
            begin
                mem_we    = (rkey != lastkey_reg);
                mem_waddr = w_reg[AW-1:0];
            end
            OP_FC_WR:
            begin
                mem_we          = 1'b1;
                mem_waddr       = i_reg[AW-1:0];
                mem_wdata       = cur_reg;
                mem_wdata.faces = fmask_reg;
            end
            OP_BS_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = mid[AW-1:0];
            end
            OP_CL_CHK:
            begin
                mem_we    = (rdata_reg.faces != '0);
                mem_waddr = w_reg[AW-1:0];
            end
            default: mem_we = 1'b0;
        endcase
    end

    // voxel memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= store_mem[mem_raddr];
        end
    end

    // advance control state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg      <= SZ_W'(1);
            sy_reg      <= SZ_W'(1);
            sz_reg      <= SZ_W'(1);
            cap_reg     <= CAP_W'(4096);
            sxy_reg     <= SXY_W'(1);
            count_reg   <= '0;
            sorted_reg  <= 1'b0;
            culled_reg  <= 1'b0;
            gidx_reg    <= '0;
            gap_reg     <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            w_reg       <= '0;
            lo_reg      <= '0;
            hi_reg      <= '0;
            before_reg  <= '0;
            fidx_reg    <= '0;
            fmask_reg   <= '0;
        end
        else
        begin
            sxy_reg <= SXY_W'(esx) * SXY_W'(esy);
            if (wr_en)
            begin
                case (wr_index)
                    REG_SIZE_X:   sx_reg  <= wr_data[SZ_W-1:0];
                    REG_SIZE_Y:   sy_reg  <= wr_data[SZ_W-1:0];
                    REG_SIZE_Z:   sz_reg  <= wr_data[SZ_W-1:0];
                    REG_CAPACITY: cap_reg <= wr_data[CAP_W-1:0];
                    default:      cap_reg <= cap_reg;
                endcase
            end
            case (cmd.op)
                OP_CLEAR:
                begin
                    count_reg  <= '0;
                    sorted_reg <= 1'b0;
                    culled_reg <= 1'b0;
                end
                OP_LOAD:
                begin
                    if (load_ok)
                    begin
                        count_reg  <= count_reg + 1'b1;
                        sorted_reg <= 1'b0;
                        culled_reg <= 1'b0;
                    end
                end
                OP_SORT_INIT: gidx_reg <= '0;
                OP_GAP_NEXT:  gidx_reg <= gidx_reg + 1'b1;
                OP_GAP_BEGIN:
                begin
                    gap_reg <= gap_cur;
                    i_reg   <= CNT_W'(gap_cur);
                end
                OP_LD_T:      j_reg <= i_reg;
                OP_SHIFT:     j_reg <= j_reg - CNT_W'(gap_reg);
                OP_PLACE:     i_reg <= i_reg + 1'b1;
                OP_SORT_DONE: sorted_reg <= 1'b1;
                OP_DD_K0:
                begin
                    i_reg <= CNT_W'(1);
                    w_reg <= CNT_W'(1);
                end
                OP_DD_CHK:
                begin
                    if (rkey != lastkey_reg)
                    begin
                        w_reg <= w_reg + 1'b1;
                    end
                    i_reg <= i_reg + 1'b1;
                end
                OP_DD_END:
                begin
                    count_reg  <= w_reg;
                    before_reg <= w_reg;
                    i_reg      <= '0;
                end
                OP_FC_LD:
                begin
                    fidx_reg  <= '0;
                    fmask_reg <= '0;
                end
                OP_FC_MISS:
                begin
                    fmask_reg <= fmask_reg | (FACE_W'(1) << fidx_reg);
                    fidx_reg  <= fidx_reg + 1'b1;
                end
                OP_FC_HIT:    fidx_reg <= fidx_reg + 1'b1;
                OP_FB_INIT, OP_QY_INIT:
                begin
                    lo_reg <= '0;
                    hi_reg <= count_reg;
                end
                OP_BS_STEP:
                begin
                    if (rkey < want_reg)
                    begin
                        lo_reg <= mid + 1'b1;
                    end
                    else
                    begin
                        hi_reg <= mid;
                    end
                end
                OP_FC_WR:     i_reg <= i_reg + 1'b1;
                OP_CL_INIT:
                begin
                    i_reg <= '0;
                    w_reg <= '0;
                end
                OP_CL_CHK:
                begin
                    if (rdata_reg.faces != '0)
                    begin
                        w_reg <= w_reg + 1'b1;
                    end
                    i_reg <= i_reg + 1'b1;
                end
                OP_CL_END:
                begin
                    count_reg  <= w_reg;
                    culled_reg <= 1'b1;
                    sorted_reg <= 1'b1;
                end
                default: count_reg <= count_reg;
            endcase
        end
    end

    // hold item fields, keys and results
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_ACCEPT:
            begin
                mode_reg        <= mode;
                px_reg          <= pos_x;
                py_reg          <= pos_y;
                pz_reg          <= pos_z;
                col_reg         <= color;
                idx_reg         <= entry_index;
                res_ok_reg      <= 1'b0;
                res_removed_reg <= '0;
                res_vox_reg     <= '0;
            end
            OP_LOAD:      res_ok_reg <= load_ok;
            OP_SORT_INIT: res_ok_reg <= 1'b1;
            OP_RD_ENTRY:  res_ok_reg <= 1'b1;
            OP_RD_OUT:    res_vox_reg <= rdata_reg;
            OP_LD_T:
            begin
                t_reg    <= rdata_reg;
                tkey_reg <= rkey;
            end
            OP_DD_K0:     lastkey_reg <= rkey;
            OP_DD_CHK:
            begin
                if (rkey != lastkey_reg)
                begin
                    lastkey_reg <= rkey;
                end
            end
            OP_FC_LD:     cur_reg <= rdata_reg;
            OP_FB_INIT:   want_reg <= nbkey;
            OP_QY_INIT:   want_reg <= qkey;
            OP_QY_HIT:    res_ok_reg <= 1'b1;
            OP_CL_END:    res_removed_reg <= before_reg - w_reg;
            default:      res_ok_reg <= res_ok_reg;
        endcase
    end

    assign ok            = res_ok_reg;
    assign removed_count = CNT_OUT_W'(res_removed_reg);
    assign voxel_count   = CNT_OUT_W'(count_reg);
    assign out_x         = res_vox_reg.x;
    assign out_y         = res_vox_reg.y;
    assign out_z         = res_vox_reg.z;
    assign out_color     = res_vox_reg.color;
    assign out_faces     = res_vox_reg.faces;

endmodule

`default_nettype wire

// File: rtl/voxel_face_culler.sv
// Top level of the voxel face culler: controller plus datapath.
// Depends on vfc_pkg, vfc_ctrl and vfc_datapath.
//
//   port group      direction  handshake
//   command word    in         start, taken when start && !busy
//   result word     out        done, one-cycle strobe, no back-pressure
//   config write    in         wr_en, wr_index, wr_data, taken every wr_en edge
//
// A valid read adds the S_RD_OUT state to the path of clear, load and an invalid read.
// A query is a binary search over the sorted voxels, one memory read per probe.
// Finish runs shell sort insertions, then a dedup pass, up to six binary
// searches per voxel and a compaction pass; once culled, it stops after
// the sort.
// Reset clears counts and flags; memory contents are not cleared. busy stays
// high from acceptance to the cycle after done; results stay until the next word.
`default_nettype none

module voxel_face_culler
    import vfc_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int MAX_EXTENT  = MAX_EXTENT_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    output logic                       done,
    input  wire logic [MODE_W-1:0]     mode,
    input  wire logic [CRD_W-1:0]      pos_x,
    input  wire logic [CRD_W-1:0]      pos_y,
    input  wire logic [CRD_W-1:0]      pos_z,
    input  wire logic [COL_W-1:0]      color,
    input  wire logic [IDX_W-1:0]      entry_index,
    output logic                       ok,
    output logic [CNT_OUT_W-1:0]       removed_count,
    output logic [CNT_OUT_W-1:0]       voxel_count,
    output logic [CRD_W-1:0]           out_x,
    output logic [CRD_W-1:0]           out_y,
    output logic [CRD_W-1:0]           out_z,
    output logic [COL_W-1:0]           out_color,
    output logic [FACE_W-1:0]          out_faces,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data
);

    dp_cmd_t    cmd;
    dp_status_t st;

    vfc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    vfc_datapath #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_EXTENT  (MAX_EXTENT)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .mode          (mode),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .color         (color),
        .entry_index   (entry_index),
        .ok            (ok),
        .removed_count (removed_count),
        .voxel_count   (voxel_count),
        .out_x         (out_x),
        .out_y         (out_y),
        .out_z         (out_z),
        .out_color     (out_color),
        .out_faces     (out_faces)
    );

endmodule

`default_nettype wire
